>>> design/nsd_pkg.sv
// Shared types and constants of the netstring deframer.
package nsd_pkg;

   // Characters of the framing
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Prefix limit register
   localparam int unsigned MAXPFX_W = 5;
   localparam logic [MAXPFX_W-1:0] MAXPFX_RESET = 5'd20;

   // Register file: one register index bit above the word offset
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic REG_MAX_PREFIX = 1'b0;

   // Result queue between parser and output
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_TERM    = 2'd2
   } phase_type;

   // Classification of a result as decided by the parser
   typedef enum logic [2:0] {
      KIND_DATA      = 3'd0,
      KIND_TERM_OK   = 3'd1,
      KIND_NO_COMMA  = 3'd2,
      KIND_BAD_DIGIT = 3'd3,
      KIND_TOO_LONG  = 3'd4,
      KIND_OVERFLOW  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_DIGIT = 3'd1,
      ST_TOO_LONG  = 3'd2,
      ST_NO_COMMA  = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } entry_type;

endpackage

>>> design/nsd_front.sv
// Front part: parses each received byte and classifies the result, if any.
module nsd_front
   import nsd_pkg::*;
#(
   parameter int unsigned LEN_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_acc,
   input  logic [7:0]          rx_byte,
   input  logic [MAXPFX_W-1:0] max_prefix,
   output logic                push,
   output entry_type           entry
);

   phase_type             phase_ff, phase_in;
   logic [LEN_WIDTH-1:0]  len_ff, len_in;
   logic [MAXPFX_W-1:0]   seen_ff, seen_in;
   logic                  bad_ff, bad_in;
   logic                  ovf_ff, ovf_in;

   logic                  is_colon, is_comma, is_digit;
   logic [3:0]            digit_diff;
   logic [MAXPFX_W-1:0]   lim;
   logic [MAXPFX_W:0]     seen_inc;
   logic                  too_long;
   logic [LEN_WIDTH+3:0]  prod;
   logic                  ovf_now;
   logic [LEN_WIDTH-1:0]  len_dec;
   logic                  len_zero;

   // Byte classification and arithmetic
   assign is_colon   = (rx_byte == CH_COLON);
   assign is_comma   = (rx_byte == CH_COMMA);
   assign is_digit   = rx_byte inside {[CH_ZERO:CH_NINE]};
   assign digit_diff = 4'(rx_byte - CH_ZERO);
   assign lim        = (max_prefix <= MAXPFX_W'(1)) ? MAXPFX_W'(1) : max_prefix;
   assign seen_inc   = {1'b0, seen_ff} + (MAXPFX_W+1)'(1);
   assign too_long   = (seen_inc >= {1'b0, lim});

   // len * 10 + digit, with four guard bits to catch overflow
   assign prod    = {1'b0, len_ff, 3'b000} + {3'b000, len_ff, 1'b0}
                  + {{LEN_WIDTH{1'b0}}, digit_diff};
   assign ovf_now = |prod[LEN_WIDTH+3:LEN_WIDTH];
   assign len_dec = len_ff - LEN_WIDTH'(1);
   assign len_zero = (len_ff == '0);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_acc) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               phase_in = (len_dec == '0) ? PH_TERM : PH_PAYLOAD;
            end
            PH_TERM: begin
               phase_in = PH_PREFIX;
            end
            default: begin
               if (is_colon && !bad_ff && !ovf_ff) begin
                  phase_in = len_zero ? PH_TERM : PH_PAYLOAD;
               end else begin
                  phase_in = PH_PREFIX;
               end
            end
         endcase
      end
   end

   // Prefix state and results
   always_comb begin
      len_in     = len_ff;
      seen_in    = seen_ff;
      bad_in     = bad_ff;
      ovf_in     = ovf_ff;
      push       = 1'b0;
      entry.kind = KIND_DATA;
      entry.data = rx_byte;
      if (in_acc) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               len_in = len_dec;
               push   = 1'b1;
            end
            PH_TERM: begin
               len_in     = '0;
               seen_in    = '0;
               bad_in     = 1'b0;
               ovf_in     = 1'b0;
               push       = 1'b1;
               entry.kind = is_comma ? KIND_TERM_OK : KIND_NO_COMMA;
            end
            default: begin
               if (is_colon) begin
                  seen_in = '0;
                  if (bad_ff || ovf_ff) begin
                     len_in     = '0;
                     bad_in     = 1'b0;
                     ovf_in     = 1'b0;
                     push       = 1'b1;
                     entry.kind = bad_ff ? KIND_BAD_DIGIT : KIND_OVERFLOW;
                  end
               end else if (too_long) begin
                  len_in     = '0;
                  seen_in    = '0;
                  bad_in     = 1'b0;
                  ovf_in     = 1'b0;
                  push       = 1'b1;
                  entry.kind = KIND_TOO_LONG;
               end else begin
                  seen_in = seen_inc[MAXPFX_W-1:0];
                  if (!is_digit) begin
                     bad_in = 1'b1;
                  end else if (!bad_ff && !ovf_ff) begin
                     if (ovf_now) begin
                        ovf_in = 1'b1;
                     end else begin
                        len_in = prod[LEN_WIDTH-1:0];
                     end
                  end
               end
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         len_ff   <= '0;
         seen_ff  <= '0;
         bad_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         bad_ff   <= bad_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Payload phase always has bytes left to count
   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> len_ff != '0)
      else $error("payload phase with zero length left");

   // Prefix error flags never survive the colon
   a_flags_prefix: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_PREFIX |-> !bad_ff && !ovf_ff)
      else $error("prefix error flag set outside prefix");

endmodule

>>> design/nsd_queue.sv
// Result queue between the parser and the output channel.
module nsd_queue
   import nsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

   entry_type         store [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = store[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

>>> design/netstring_deframer.sv
// Top level of the netstring deframer: parser, result queue, output and registers.
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  req_rx_byte
//  rsp_     out        rsp_valid/rsp_stall  rsp_data_byte, rsp_last_of_frame, rsp_status
//  csr_     in/out     APB psel/penable     max_prefix_bytes at byte address 0
//
// One byte a cycle is accepted while req_stall is low; its result, if any, is registered
// into the result queue. The parser updates its state with one multiply-by-ten add
// per byte, so the rate is one transaction per cycle unless req_stall holds the input.
// req_stall rises only when the four-entry result queue is full.
// Synchronous reset clears the parser and queue and sets the limit to 20.
module netstring_deframer
   import nsd_pkg::*;
#(
   parameter int unsigned LEN_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_last_of_frame,
   output logic [2:0]            rsp_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [MAXPFX_W-1:0] max_prefix_ff, max_prefix_in;
   logic                csr_wr;
   logic                in_acc;
   logic                push;
   entry_type           push_entry;
   logic                pop;
   logic                q_full;
   logic                q_not_empty;
   entry_type           head;
   status_type          status;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr[2] == REG_MAX_PREFIX);
   assign max_prefix_in = csr_wr ? csr_pwdata[MAXPFX_W-1:0] : max_prefix_ff;
   assign csr_prdata    = (csr_paddr[2] == REG_MAX_PREFIX) ? 32'(max_prefix_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_prefix_ff <= MAXPFX_RESET;
      end else begin
         max_prefix_ff <= max_prefix_in;
      end
   end

   // Input transaction
   assign req_stall = q_full;
   assign in_acc    = req_valid && !req_stall;

   nsd_front #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_acc     (in_acc),
      .rx_byte    (req_rx_byte),
      .max_prefix (max_prefix_ff),
      .push       (push),
      .entry      (push_entry)
   );

   nsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (head)
   );

   // Output formatting from the queue head
   assign rsp_valid = q_not_empty;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      case (head.kind)
         KIND_DATA:      status = ST_OK;
         KIND_TERM_OK:   status = ST_OK;
         KIND_NO_COMMA:  status = ST_NO_COMMA;
         KIND_BAD_DIGIT: status = ST_BAD_DIGIT;
         KIND_TOO_LONG:  status = ST_TOO_LONG;
         KIND_OVERFLOW:  status = ST_OVERFLOW;
         default:        status = ST_OK;
      endcase
   end

   assign rsp_data_byte     = (head.kind == KIND_TERM_OK) ? CH_NEWLINE : head.data;
   assign rsp_last_of_frame = (head.kind != KIND_DATA);
   assign rsp_status        = status;

endmodule

>>> bench/tb.sv
// Self-checking bench for the netstring deframer: byte stream in, payload and errors out.
module tb;
   import nsd_pkg::*;

   localparam int unsigned LEN_W = 32;
   localparam logic [63:0] LEN_MAX = (LEN_W >= 64) ? '1 : ((64'd1 << LEN_W) - 64'd1);
   localparam logic [CSR_ADDR_W-1:0] ADDR_LIMIT  = {REG_MAX_PREFIX, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = {~REG_MAX_PREFIX, 2'b00};
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 300;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_BYTES   = 120;
   localparam int MAX_SAFE_LEN  = 64;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   // One deframed result as it should leave the block
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      status_type status;
   } deframed_type;

   // Tracks the parser state and holds the results still due
   class frame_tracker;
      deframed_type  due[$];
      phase_type     phase;
      logic [63:0]   remaining;
      int unsigned   seen;
      bit            bad_digit;
      bit            overflow;
      logic [4:0]    limit;

      function new();
         limit = MAXPFX_RESET;
         clear_prefix();
      endfunction

      function void clear_prefix();
         phase     = PH_PREFIX;
         remaining = '0;
         seen      = 0;
         bad_digit = 1'b0;
         overflow  = 1'b0;
      endfunction

      function void set_limit(logic [4:0] v);
         limit = v;
      endfunction

      function void push(logic [7:0] data, logic last, status_type st);
         deframed_type r;
         r.data   = data;
         r.last   = last;
         r.status = st;
         due.push_back(r);
      endfunction

      function int outstanding();
         return due.size();
      endfunction

      // A colon now would open a payload too long for the bench to feed
      function bit colon_hazard();
         return phase != PH_PAYLOAD && phase != PH_TERM && !bad_digit && !overflow &&
                remaining > MAX_SAFE_LEN;
      endfunction

      // Note one accepted input transaction
      function void take_byte(logic [7:0] b);
         int unsigned lim;
         logic [63:0] digit;
         case (phase)
            PH_PAYLOAD: begin
               remaining = (remaining - 64'd1) & LEN_MAX;
               if (remaining == 0) phase = PH_TERM;
               push(b, 1'b0, ST_OK);
            end
            PH_TERM: begin
               clear_prefix();
               if (b == CH_COMMA) push(CH_NEWLINE, 1'b1, ST_OK);
               else push(b, 1'b1, ST_NO_COMMA);
            end
            default: begin
               if (b == CH_COLON) begin
                  if (bad_digit) begin
                     clear_prefix();
                     push(b, 1'b1, ST_BAD_DIGIT);
                  end else if (overflow) begin
                     clear_prefix();
                     push(b, 1'b1, ST_OVERFLOW);
                  end else begin
                     seen  = 0;
                     phase = (remaining == 0) ? PH_TERM : PH_PAYLOAD;
                  end
               end else begin
                  // a limit of zero or one still allows a bare colon
                  lim = (limit < 1) ? 1 : limit;
                  if (seen + 1 >= lim) begin
                     clear_prefix();
                     push(b, 1'b1, ST_TOO_LONG);
                  end else begin
                     seen = seen + 1;
                     if (b < CH_ZERO || b > CH_NINE) begin
                        bad_digit = 1'b1;
                     end else if (!bad_digit && !overflow) begin
                        digit = 64'(b) - 64'(CH_ZERO);
                        if (remaining > (LEN_MAX - digit) / 10) overflow = 1'b1;
                        else remaining = remaining * 10 + digit;
                     end
                  end
               end
            end
         endcase
      endfunction

      // Compare one output transaction with the oldest result due
      function string match_result(logic [7:0] data, logic last, logic [2:0] status);
         deframed_type want;
         string        msg;
         if (due.size() == 0)
            return $sformatf("unexpected result data=%02h last=%0b status=%0d",
                             data, last, status);
         want = due.pop_front();
         msg  = "";
         if (data !== want.data)
            msg = {msg, $sformatf(" data got %02h want %02h", data, want.data)};
         if (last !== want.last)
            msg = {msg, $sformatf(" last got %0b want %0b", last, want.last)};
         if (status !== want.status)
            msg = {msg, $sformatf(" status got %0d want %0d", status, want.status)};
         return msg;
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last_of_frame;
   logic [2:0]  rsp_status;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frame_tracker sb = new();

   int mismatches   = 0;
   int bytes_in     = 0;
   int results_out  = 0;
   int terms_ok     = 0;
   int settings_run = 0;
   int status_hits[8];
   bit tx_quiet     = 1'b0;
   bit rx_quiet     = 1'b0;
   bit hold_request = 1'b0;

   netstring_deframer #(.LEN_WIDTH(LEN_W)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 30) $display("mismatch at %0t:%s", $time, msg);
   endtask

   // Sender gap: mostly none, sometimes short, rarely long
   function automatic int tx_gap();
      int r;
      if (tx_quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one byte and wait until the transaction is taken
   task automatic send_byte(input logic [7:0] b);
      int         gap;
      logic [7:0] v;
      gap = tx_gap();
      v   = b;
      if (v == CH_COLON && sb.colon_hazard()) v = CH_SEMI;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= v;
      do @(posedge clock); while (req_stall);
      sb.take_byte(v);
      bytes_in++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] any_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] any_non_digit();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while ((v >= CH_ZERO && v <= CH_NINE) || v == CH_COLON);
      return v;
   endfunction

   // Drop valid, wait for every result and let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_LIMIT) sb.set_limit(data[MAXPFX_W-1:0]);
   endtask

   // Read the limit register back and compare with the tracked value
   task automatic check_limit_reg();
      logic [31:0] v;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_LIMIT;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      v = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (v !== {27'd0, sb.limit})
         report_mismatch($sformatf(" limit register reads %08h want %0d", v, sb.limit));
   endtask

   task automatic set_limit_reg(input logic [4:0] lim);
      csr_write(ADDR_LIMIT, {$urandom} & 32'hFFFF_FFE0 | {27'd0, lim});
      check_limit_reg();
      settings_run++;
   endtask

   // Good or broken frame: length prefix, colon, payload, terminator
   task automatic send_frame(input bit good_term);
      int         len;
      int         r;
      string      prefix;
      logic [7:0] t;
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(0, 6);
      else if (r < 95) len = $urandom_range(7, 20);
      else len = $urandom_range(21, 60);
      prefix = $sformatf("%0d", len);
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) prefix = {"0", prefix};
      send_text(prefix);
      send_byte(CH_COLON);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      if (good_term) begin
         send_byte(CH_COMMA);
      end else begin
         do t = 8'($urandom_range(0, 255)); while (t == CH_COMMA);
         send_byte(t);
      end
   endtask

   task automatic send_bad_prefix();
      repeat ($urandom_range(0, 3)) send_byte(any_digit());
      send_byte(any_non_digit());
      repeat ($urandom_range(0, 2)) send_byte(any_digit());
      send_byte(CH_COLON);
   endtask

   task automatic send_long_prefix();
      repeat (sb.limit + $urandom_range(0, 2)) send_byte(any_digit());
   endtask

   task automatic send_overflow();
      if ($urandom_range(0, 1)) begin
         send_text("4294967296");
      end else begin
         send_byte(CH_ZERO + 8'($urandom_range(1, 9)));
         repeat ($urandom_range(10, 14)) send_byte(any_digit());
      end
      send_byte(CH_COLON);
   endtask

   // Mostly well-formed frames with random content, the rest broken or noise
   task automatic random_traffic(input int n_bytes, input bit with_pause);
      int start;
      int r;
      bit paused;
      start  = bytes_in;
      paused = 1'b0;
      while (bytes_in - start < n_bytes) begin
         r = $urandom_range(0, 99);
         if (r < 65) send_frame(1'b1);
         else if (r < 72) send_frame(1'b0);
         else if (r < 80) send_bad_prefix();
         else if (r < 86) send_long_prefix();
         else if (r < 92) send_overflow();
         else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         if (with_pause && !paused && bytes_in - start > n_bytes / 2) begin
            // sender holds back until the output has fully drained
            paused = 1'b1;
            req_valid <= 1'b0;
            while (sb.outstanding() > 0) @(posedge clock);
         end
      end
   endtask

   // Output side: check each transaction, then choose the next stall
   initial begin : receiver
      int    hold_left;
      string msg;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            msg = sb.match_result(rsp_data_byte, rsp_last_of_frame, rsp_status);
            if (msg != "") report_mismatch(msg);
            results_out++;
            status_hits[rsp_status]++;
            if (rsp_status == ST_OK && rsp_last_of_frame) terms_ok++;
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (rx_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4: begin
                  rsp_stall <= 1'b1;
                  hold_left = $urandom_range(0, 2);
               end
               5: begin
                  rsp_stall <= 1'b1;
                  hold_left = $urandom_range(9, 39);
               end
               default: rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // Ends the run when no transaction moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      logic [4:0] plan[10];
      plan = '{5'd31, 5'd2, 5'd20, 5'd5, 5'd0, 5'd14, 5'd1, 5'd3, 5'd25, 5'd20};
      plan[9] = 5'($urandom_range(2, 20));
      wait (reset == 1'b0);
      @(posedge clock);
      check_limit_reg();
      settings_run++;

      // Directed: empty and zero lengths, byte extremes, each error kind
      send_text("0:,");
      send_text(":,");
      send_text("2:");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_COMMA);
      send_text("1:x!");
      send_text("1z:");
      send_text("4294967296:");
      // limit lowered while a prefix is half built
      send_text("1");
      settle();
      set_limit_reg(5'd2);
      send_text("2");
      send_text("5:a,");
      settle();
      set_limit_reg(5'd1);
      send_text(":,7");
      settle();
      set_limit_reg(5'd0);
      send_text(":,5");
      settle();
      // a write to an unused address must leave the limit alone
      csr_write(ADDR_UNUSED, {$urandom});
      check_limit_reg();

      // Random phases over a spread of limits
      for (int p = 0; p < 10; p++) begin
         settle();
         set_limit_reg(plan[p]);
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         if (p == 2) begin
            tx_quiet     = 1'b1;
            hold_request = 1'b1;
         end
         random_traffic(PHASE_BYTES, p == 4);
      end

      settle();
      repeat (10) @(posedge clock);
      if (sb.outstanding() != 0)
         report_mismatch($sformatf(" %0d results never arrived", sb.outstanding()));
      $display("run: %0d bytes in, %0d results out, %0d limit settings",
               bytes_in, results_out, settings_run);
      $display("frames closed %0d; errors: digit %0d, too long %0d, comma %0d, overflow %0d",
               terms_ok, status_hits[ST_BAD_DIGIT], status_hits[ST_TOO_LONG],
               status_hits[ST_NO_COMMA], status_hits[ST_OVERFLOW]);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/nsd_pkg.sv
design/nsd_front.sv
design/nsd_queue.sv
design/netstring_deframer.sv
bench/tb.sv
